FILE: sv/bloom_filter_insert_query_assert.svh
// ----------------------------------------------------------------------------
// bloom filter assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_INSERT_QUERY_ASSERT_SVH
`define BLOOM_FILTER_INSERT_QUERY_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BFIQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFIQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// shared widths, codes, modulo unit request/status types and the restoring mod step
// ----------------------------------------------------------------------------
`default_nettype none

package bfiq_pkg;

  localparam int HASH_W   = 64;                      // key hash half width
  localparam int IDX_W    = 18;                      // bit index / modulus width
  localparam int BIT_W    = 6;                       // bit position inside a word
  localparam int WORD_W   = 64;                      // store word width
  localparam int WIDX_W   = IDX_W - BIT_W;           // word index before wrap
  localparam int MOD_BITS = 8;                       // dividend bits per cycle
  localparam int HASH_CYC = HASH_W / MOD_BITS;
  localparam int WORD_CYC = (WIDX_W + MOD_BITS - 1) / MOD_BITS;
  localparam int WORD_SHIFT = HASH_W - WORD_CYC * MOD_BITS;
  localparam int CNT_W    = $clog2(HASH_CYC + 1);

  // operation on in_req_type
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [3:0] REG_BIT_COUNT   = 4'd0;
  localparam logic [3:0] REG_PROBE_COUNT = 4'd1;

  typedef struct packed {
    logic              go;
    logic [HASH_W-1:0] dividend;   // consumed msb first
    logic [CNT_W-1:0]  cycles;     // number of MOD_BITS chunks
    logic [IDX_W-1:0]  rem_init;   // must be below divisor
    logic [IDX_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_sts_t;

  // one restoring step: shift a dividend bit into the remainder
  function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
                                                input logic             din,
                                                input logic [IDX_W-1:0] div);
    logic [IDX_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, div}) begin
      t = t - {1'b0, div};
    end
    return t[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/bfiq_mod_unit.sv
// ----------------------------------------------------------------------------
// bfiq_mod_unit
// shared iterative remainder unit, MOD_BITS dividend bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_mod_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire bfiq_pkg::mod_req_t  req,
  output bfiq_pkg::mod_sts_t       sts
);

  logic                         busy_r;
  logic                         done_r;
  logic [bfiq_pkg::CNT_W-1:0]   cnt_r;
  logic [bfiq_pkg::HASH_W-1:0]  sh_r;
  logic [bfiq_pkg::IDX_W-1:0]   rem_r;
  logic [bfiq_pkg::IDX_W-1:0]   div_r;
  logic [bfiq_pkg::IDX_W-1:0]   rem_nxt;

  // chunk of restoring steps on the current top bits
  always_comb begin
    rem_nxt = rem_r;
    for (int j = 0; j < bfiq_pkg::MOD_BITS; j++) begin
      rem_nxt = bfiq_pkg::mod_step(rem_nxt, sh_r[bfiq_pkg::HASH_W-1-j], div_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.cycles - bfiq_pkg::CNT_W'(1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - bfiq_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      sh_r  <= req.dividend;
      rem_r <= req.rem_init;
      div_r <= req.divisor;
    end else if (busy_r) begin
      sh_r  <= sh_r << bfiq_pkg::MOD_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.rem  = rem_r;

endmodule

`default_nettype wire

FILE: sv/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// bloom filter bit store with double hashing probes, add and query
// ----------------------------------------------------------------------------
//
// channel  | ports                                        | handshake
// ---------+----------------------------------------------+---------------------------
// input    | in_req_type, in_hash_first, in_hash_second   | start && !busy
// result   | out_present                                  | out_valid, one cycle
// config   | cfg_index, cfg_data                          | cfg_valid && cfg_ready
//
// reset sweeps the store clear, one word a cycle over all STORE_WORDS words, busy high
// an add or a query with k > 0 probes first takes hash_first and hash_second mod m
// on the shared remainder unit, then each probe is a read plus a write or test
// after reset or a bit_count write, 2^64 mod m is computed once first; a store size
// not a power of two and below 4096 words adds a word index reduction per probe
// a query stops at its first clear bit; the result strobe cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_query #(
  parameter int STORE_WORDS = 2048,
  parameter int MAX_PROBES  = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // input transaction
  input  wire                           start,
  output logic                          busy,
  input  wire                           in_req_type,
  input  wire [bfiq_pkg::HASH_W-1:0]    in_hash_first,
  input  wire [bfiq_pkg::HASH_W-1:0]    in_hash_second,
  // result transaction
  output logic                          out_valid,
  output logic                          out_present,
  // configuration writes
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [3:0]                     cfg_index,
  input  wire [bfiq_pkg::IDX_W-1:0]     cfg_data
);

  localparam int IW = bfiq_pkg::IDX_W;
  localparam int HW = bfiq_pkg::HASH_W;
  localparam int WW = bfiq_pkg::WIDX_W;
  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int CW = bfiq_pkg::CNT_W;

  // word index needs no reduction when the store is a power of two or covers
  // every word index an 18-bit bit index can reach
  localparam bit DirectWord = (STORE_WORDS >= (1 << WW)) ||
                              ((STORE_WORDS & (STORE_WORDS - 1)) == 0);
  localparam logic [IW-1:0] SwDiv = IW'(STORE_WORDS);

  localparam logic [3:0] REG_BIT_COUNT   = bfiq_pkg::REG_BIT_COUNT;
  localparam logic [3:0] REG_PROBE_COUNT = bfiq_pkg::REG_PROBE_COUNT;
  localparam logic       REQ_ADD         = bfiq_pkg::REQ_ADD;
  localparam logic       REQ_QUERY       = bfiq_pkg::REQ_QUERY;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_POW,
    S_FMOD,
    S_SMOD,
    S_WWAIT,
    S_READ,
    S_USE
  } state_t;

  // control and config
  state_t             state_r, state_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_present_r, out_present_nxt;
  logic [IW-1:0]      bit_count_r, bit_count_nxt;
  logic [4:0]         probe_count_r, probe_count_nxt;
  logic               pow_ok_r, pow_ok_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [PW-1:0]      k_r, k_nxt;
  logic [PW-1:0]      p_r, p_nxt;

  // transaction payload
  logic               req_r, req_nxt;
  logic [HW-1:0]      h_r, h_nxt;
  logic [HW-1:0]      second_r, second_nxt;
  logic [IW-1:0]      r_r, r_nxt;          // current probe index mod m
  logic [IW-1:0]      s_r, s_nxt;          // stride mod m
  logic [IW-1:0]      c_r, c_nxt;          // 2^64 mod m
  logic [AW-1:0]      word_r, word_nxt;

  // datapath
  logic [IW-1:0]      m_eff;
  logic [PW-1:0]      k_sat;
  logic [IW:0]        t_sum;
  logic [IW:0]        u_red;
  logic [IW:0]        v_fix;
  logic               h_carry;
  logic [HW-1:0]      h_adv;
  logic [IW-1:0]      r_adv;
  logic               to_word;
  logic [IW-1:0]      word_src;
  logic [AW-1:0]      word_addr;
  logic               probe_bit;

  // store
  logic [bfiq_pkg::WORD_W-1:0] mem [STORE_WORDS];
  logic [bfiq_pkg::WORD_W-1:0] rd_data_r;
  logic                        mem_we;
  logic                        mem_re;
  logic [AW-1:0]               mem_waddr;
  logic [bfiq_pkg::WORD_W-1:0] mem_wdata;

  bfiq_pkg::mod_req_t mod_req;
  bfiq_pkg::mod_sts_t mod_sts;

  // check terms
  logic               accept_probes;
  logic               query_test;

  function automatic logic [AW-1:0] word_direct(input logic [WW-1:0] w);
    if (STORE_WORDS == 1) begin
      return '0;
    end
    return AW'(w);
  endfunction

  // zero bit count acts as one
  assign m_eff = (bit_count_r == '0) ? IW'(1) : bit_count_r;
  assign k_sat = (32'(probe_count_r) > MAX_PROBES) ? PW'(MAX_PROBES) : PW'(probe_count_r);

  // next probe index: add stride mod m, take back 2^64 mod m on wrap
  always_comb begin
    {h_carry, h_adv} = {1'b0, h_r} + {1'b0, second_r};
    t_sum = {1'b0, r_r} + {1'b0, s_r};
    u_red = (t_sum >= {1'b0, m_eff}) ? (t_sum - {1'b0, m_eff}) : t_sum;
    if (!h_carry) begin
      v_fix = u_red;
    end else if (u_red >= {1'b0, c_r}) begin
      v_fix = u_red - {1'b0, c_r};
    end else begin
      v_fix = u_red + {1'b0, m_eff} - {1'b0, c_r};
    end
    r_adv = v_fix[IW-1:0];
  end

  assign word_addr = DirectWord ? word_direct(r_r[IW-1:bfiq_pkg::BIT_W]) : word_r;
  assign probe_bit = rd_data_r[r_r[bfiq_pkg::BIT_W-1:0]];
  assign word_src  = (state_r == S_USE) ? r_adv : r_r;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = 1'b0;
    out_present_nxt = out_present_r;
    bit_count_nxt   = bit_count_r;
    probe_count_nxt = probe_count_r;
    pow_ok_nxt      = pow_ok_r;
    clr_nxt         = clr_r;
    k_nxt           = k_r;
    p_nxt           = p_r;
    req_nxt         = req_r;
    h_nxt           = h_r;
    second_nxt      = second_r;
    r_nxt           = r_r;
    s_nxt           = s_r;
    c_nxt           = c_r;
    word_nxt        = word_r;
    to_word         = 1'b0;

    mod_req.go       = 1'b0;
    mod_req.dividend = second_r;
    mod_req.cycles   = CW'(bfiq_pkg::HASH_CYC);
    mod_req.rem_init = '0;
    mod_req.divisor  = m_eff;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_COUNT: begin
          bit_count_nxt = cfg_data;
          pow_ok_nxt    = 1'b0;
        end
        REG_PROBE_COUNT: begin
          probe_count_nxt = cfg_data[4:0];
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(STORE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req_type;
          h_nxt      = in_hash_first;
          second_nxt = in_hash_second;
          k_nxt      = k_sat;
          if (k_sat == '0) begin
            // nothing probed: a query answers present
            if (in_req_type == REQ_QUERY) begin
              out_valid_nxt   = 1'b1;
              out_present_nxt = 1'b1;
            end
          end else if (!pow_ok_r) begin
            mod_req.go       = 1'b1;
            mod_req.dividend = '0;
            mod_req.rem_init = (m_eff == IW'(1)) ? '0 : IW'(1);
            state_nxt        = S_POW;
          end else begin
            mod_req.go       = 1'b1;
            mod_req.dividend = in_hash_first;
            state_nxt        = S_FMOD;
          end
        end
      end
      S_POW: begin
        if (mod_sts.done) begin
          c_nxt            = mod_sts.rem;
          pow_ok_nxt       = 1'b1;
          mod_req.go       = 1'b1;
          mod_req.dividend = h_r;
          state_nxt        = S_FMOD;
        end
      end
      S_FMOD: begin
        if (mod_sts.done) begin
          r_nxt            = mod_sts.rem;
          mod_req.go       = 1'b1;
          mod_req.dividend = second_r;
          state_nxt        = S_SMOD;
        end
      end
      S_SMOD: begin
        if (mod_sts.done) begin
          s_nxt   = mod_sts.rem;
          p_nxt   = '0;
          to_word = 1'b1;
        end
      end
      S_WWAIT: begin
        if (mod_sts.done) begin
          word_nxt  = mod_sts.rem[AW-1:0];
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_USE;
      end
      S_USE: begin
        if (req_r == REQ_QUERY && !probe_bit) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end else if (p_r == k_r - PW'(1)) begin
          if (req_r == REQ_QUERY) begin
            out_valid_nxt   = 1'b1;
            out_present_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end else begin
          p_nxt   = p_r + PW'(1);
          r_nxt   = r_adv;
          h_nxt   = h_adv;
          to_word = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // word index of the next probe
    if (to_word) begin
      if (DirectWord) begin
        state_nxt = S_READ;
      end else begin
        mod_req.go       = 1'b1;
        mod_req.dividend = HW'(word_src[IW-1:bfiq_pkg::BIT_W]) << bfiq_pkg::WORD_SHIFT;
        mod_req.cycles   = CW'(bfiq_pkg::WORD_CYC);
        mod_req.rem_init = '0;
        mod_req.divisor  = SwDiv;
        state_nxt        = S_WWAIT;
      end
    end

    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      busy_r        <= 1'b1;
      out_valid_r   <= 1'b0;
      out_present_r <= 1'b0;
      bit_count_r   <= IW'(131072);
      probe_count_r <= 5'd6;
      pow_ok_r      <= 1'b0;
      clr_r         <= '0;
      k_r           <= '0;
      p_r           <= '0;
    end else begin
      state_r       <= state_nxt;
      busy_r        <= busy_nxt;
      out_valid_r   <= out_valid_nxt;
      out_present_r <= out_present_nxt;
      bit_count_r   <= bit_count_nxt;
      probe_count_r <= probe_count_nxt;
      pow_ok_r      <= pow_ok_nxt;
      clr_r         <= clr_nxt;
      k_r           <= k_nxt;
      p_r           <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    h_r      <= h_nxt;
    second_r <= second_nxt;
    r_r      <= r_nxt;
    s_r      <= s_nxt;
    c_r      <= c_nxt;
    word_r   <= word_nxt;
  end

  // shared remainder unit
  bfiq_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .sts   (mod_sts)
  );

  // bit store: clearing sweep, then read-modify-write for adds
  assign mem_re    = (state_r == S_READ);
  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_USE && req_r == REQ_ADD);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : word_addr;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 :
                     (rd_data_r | (bfiq_pkg::WORD_W'(1) << r_r[bfiq_pkg::BIT_W-1:0]));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[word_addr];
    end
  end

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_present = out_present_r;
  assign cfg_ready   = 1'b1;

  // checks
  assign accept_probes = start && !busy_r && (k_sat != '0);
  assign query_test    = (state_r == S_USE) && (req_r == REQ_QUERY);

  `include "bloom_filter_insert_query_assert.svh"

  `BFIQ_ASSERT_SAME(a_result_when_idle, out_valid_r, !busy_r, "result strobe while busy")
  `BFIQ_ASSERT_NEXT(a_accept_goes_busy, accept_probes, busy_r, "accept did not go busy")
  `BFIQ_ASSERT_SAME(a_mod_go_when_free, mod_req.go, !mod_sts.busy, "remainder unit restarted")
  `BFIQ_ASSERT_SAME(a_query_no_write, query_test, !mem_we, "query wrote the bit store")

endmodule

`default_nettype wire
